### sv/greedy_centroid_tracker_assert.svh
// Assertion macros for the centroid tracker.
`ifndef GREEDY_CENTROID_TRACKER_ASSERT_SVH
`define GREEDY_CENTROID_TRACKER_ASSERT_SVH
`ifndef SYNTHESIS
// Consequent holds in the same cycle as the antecedent.
`define GCT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Consequent holds in the cycle after the antecedent.
`define GCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define GCT_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define GCT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### sv/gct_pkg.sv
`timescale 1ns / 1ps
package gct_pkg;

    // Configuration register indexes.
    localparam logic CFG_MISSING_LIMIT = 1'b0;
    localparam logic CFG_MATCH_RADIUS  = 1'b1;

    localparam int unsigned CFG_DW = 13;
    localparam int unsigned D2_W   = 27;

    typedef struct packed {
        logic        mode;
        logic [7:0]  obj_class;
        logic [11:0] box_x;
        logic [11:0] box_y;
        logic [11:0] box_w;
        logic [11:0] box_h;
    } t_in_item;

    typedef struct packed {
        logic        valid_res;
        logic [31:0] track_id;
        logic [12:0] center_x;
        logic [12:0] center_y;
        logic [11:0] out_x;
        logic [11:0] out_y;
        logic [11:0] out_w;
        logic [11:0] out_h;
        logic        age;
        logic        overflow;
        logic        last;
    } t_out_item;

    // One track table entry as held in the slot memory.
    typedef struct packed {
        logic [31:0] id;
        logic [12:0] cx;
        logic [12:0] cy;
        logic [11:0] bx;
        logic [11:0] by;
        logic [11:0] bw;
        logic [11:0] bh;
        logic [7:0]  age;
    } t_entry;

endpackage

### sv/gct_slot_mem.sv
`timescale 1ns / 1ps
module gct_slot_mem
    import gct_pkg::*;
#(
    parameter int unsigned DEPTH = 32,
    parameter int unsigned AW    = 5
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    // Single write port, single registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/gct_dist.sv
`timescale 1ns / 1ps
module gct_dist
    import gct_pkg::*;
#(
    parameter int unsigned AW = 5
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_v,
    input  logic [AW-1:0]   i_idx,
    input  logic [31:0]     i_id,
    input  logic [12:0]     i_scx,
    input  logic [12:0]     i_scy,
    input  logic [12:0]     i_dcx,
    input  logic [12:0]     i_dcy,
    output logic            o_v,
    output logic [AW-1:0]   o_idx,
    output logic [31:0]     o_id,
    output logic [D2_W-1:0] o_d2
);

    logic [12:0]     dx;
    logic [12:0]     dy;
    logic            r_v1;
    logic [AW-1:0]   r_idx1;
    logic [31:0]     r_id1;
    logic [25:0]     r_dx2;
    logic [25:0]     r_dy2;
    logic            r_v2;
    logic [AW-1:0]   r_idx2;
    logic [31:0]     r_id2;
    logic [D2_W-1:0] r_d2;

    // Absolute differences of the centroid coordinates.
    assign dx = (i_scx > i_dcx) ? (i_scx - i_dcx) : (i_dcx - i_scx);
    assign dy = (i_scy > i_dcy) ? (i_scy - i_dcy) : (i_dcy - i_scy);

    // Stage one squares, stage two sums.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_v;
            r_v2 <= r_v1;
        end
        r_idx1 <= i_idx;
        r_id1  <= i_id;
        r_dx2  <= 26'(dx) * 26'(dx);
        r_dy2  <= 26'(dy) * 26'(dy);
        r_idx2 <= r_idx1;
        r_id2  <= r_id1;
        r_d2   <= D2_W'(r_dx2) + D2_W'(r_dy2);
    end

    assign o_v   = r_v2;
    assign o_idx = r_idx2;
    assign o_id  = r_id2;
    assign o_d2  = r_d2;

endmodule

### sv/greedy_centroid_tracker.sv
`timescale 1ns / 1ps
// A detection holds the input stall through ST_DISP when ignored, through ST_DISP and
// ST_UPD when registered into an empty-start frame, and through ST_DISP, ST_SCAN and
// ST_UPD when compared against the table. A frame opening on a non-empty table adds an
// age sweep over every slot. End of frame: a prune sweep, then one selection pass per
// emitted track, since each pass reads the whole slot memory for the smallest id.
// Synchronous active-low reset empties the table at once; no clearing pass.
module greedy_centroid_tracker
    import gct_pkg::*;
#(
    parameter int unsigned MAX_TRACKS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_data,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [CFG_DW-1:0] i_cfg_data
);

    `include "greedy_centroid_tracker_assert.svh"

    localparam int unsigned AW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
    localparam int unsigned CW = $clog2(MAX_TRACKS + 3);
    localparam logic [CW-1:0] CNT_N    = CW'(MAX_TRACKS);
    localparam logic [CW-1:0] CNT_SCAN = CW'(MAX_TRACKS + 2);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_AGE   = 7'b0000010,
        ST_DISP  = 7'b0000100,
        ST_SCAN  = 7'b0001000,
        ST_UPD   = 7'b0010000,
        ST_PRUNE = 7'b0100000,
        ST_SORT  = 7'b1000000
    } t_state;

    // Emission step is folded into the sort pass end through r_emit.
    t_state                r_state, n_state;
    logic                  r_emit, n_emit;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [MAX_TRACKS-1:0] r_valid, n_valid;
    logic [MAX_TRACKS-1:0] r_elig, n_elig;
    logic [MAX_TRACKS-1:0] v_mask;
    logic                  r_frame_open, n_frame_open;
    logic                  r_started_empty, n_started_empty;
    logic                  r_ovf, n_ovf;
    logic [31:0]           r_next_id, n_next_id;
    logic [7:0]            r_limit;
    logic [12:0]           r_radius;
    t_in_item              r_item, n_item;
    logic [12:0]           r_dcx, n_dcx;
    logic [12:0]           r_dcy, n_dcy;
    logic [25:0]           r_r2, n_r2;
    logic                  r_found, n_found;
    t_entry                r_best, n_best;
    logic [AW-1:0]         r_best_idx, n_best_idx;
    logic [D2_W-1:0]       r_best_d2, n_best_d2;
    logic                  r_rd_v;
    logic [AW-1:0]         r_rd_idx;
    logic                  r_out_valid, n_out_valid;
    t_out_item             r_out, n_out;

    logic                  in_acc;
    logic                  out_free;
    logic                  any_valid;
    logic                  has_free;
    logic [AW-1:0]         free_idx;
    logic                  issue;
    logic                  mem_we;
    logic [AW-1:0]         mem_wa;
    t_entry                mem_wd;
    t_entry                mem_rd;
    logic                  d_v;
    logic [AW-1:0]         d_idx;
    logic [31:0]           d_id;
    logic [D2_W-1:0]       d_d2;
    logic                  emit_last;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign any_valid  = |r_valid;
    assign has_free   = ~&r_valid;
    assign issue      = (r_state == ST_AGE || r_state == ST_SCAN || r_state == ST_PRUNE
                         || (r_state == ST_SORT && !r_emit)) && (r_cnt < CNT_N);

    // Lowest free slot.
    always_comb begin
        free_idx = '0;
        for (int i = MAX_TRACKS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_idx = AW'(i);
            end
        end
    end

    // Remaining eligible slots once the current best is sent.
    always_comb begin
        v_mask = r_elig;
        v_mask[r_best_idx] = 1'b0;
    end
    assign emit_last = (v_mask == '0);

    gct_slot_mem #(
        .DEPTH (MAX_TRACKS),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_wa),
        .i_wdata (mem_wd),
        .i_re    (issue),
        .i_raddr (r_cnt[AW-1:0]),
        .o_rdata (mem_rd)
    );

    gct_dist #(
        .AW (AW)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_v     (r_rd_v && r_state == ST_SCAN),
        .i_idx   (r_rd_idx),
        .i_id    (mem_rd.id),
        .i_scx   (mem_rd.cx),
        .i_scy   (mem_rd.cy),
        .i_dcx   (r_dcx),
        .i_dcy   (r_dcy),
        .o_v     (d_v),
        .o_idx   (d_idx),
        .o_id    (d_id),
        .o_d2    (d_d2)
    );

    // Sequencer.
    always_comb begin
        n_state         = r_state;
        n_emit          = r_emit;
        n_cnt           = r_cnt;
        n_valid         = r_valid;
        n_elig          = r_elig;
        n_frame_open    = r_frame_open;
        n_started_empty = r_started_empty;
        n_ovf           = r_ovf;
        n_next_id       = r_next_id;
        n_item          = r_item;
        n_dcx           = r_dcx;
        n_dcy           = r_dcy;
        n_r2            = r_r2;
        n_found         = r_found;
        n_best          = r_best;
        n_best_idx      = r_best_idx;
        n_best_d2       = r_best_d2;
        n_out_valid     = r_out_valid && i_out_stall;
        n_out           = r_out;
        mem_we          = 1'b0;
        mem_wa          = r_rd_idx;
        mem_wd          = mem_rd;
        if (issue) begin
            n_cnt = r_cnt + 1'b1;
        end else if (r_state == ST_SCAN) begin
            n_cnt = r_cnt + 1'b1;
        end
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_item = i_in_data;
                    n_dcx  = {1'b0, i_in_data.box_x} + 13'(i_in_data.box_w[11:1]);
                    n_dcy  = {1'b0, i_in_data.box_y} + 13'(i_in_data.box_h[11:1]);
                    n_r2   = 26'(r_radius) * 26'(r_radius);
                    n_cnt  = '0;
                    if (!r_frame_open) begin
                        n_frame_open    = 1'b1;
                        n_started_empty = !any_valid;
                        n_ovf           = 1'b0;
                        n_state         = any_valid ? ST_AGE : ST_DISP;
                    end else begin
                        n_state = ST_DISP;
                    end
                end
            end
            ST_AGE: begin
                // Read-modify-write of each age, one slot behind the read.
                if (r_rd_v && r_valid[r_rd_idx]) begin
                    mem_we = 1'b1;
                    if (mem_rd.age != 8'hFF) begin
                        mem_wd.age = mem_rd.age + 8'd1;
                    end
                end
                if (r_cnt == CNT_N) begin
                    n_state = ST_DISP;
                end
            end
            ST_DISP: begin
                n_cnt     = '0;
                n_found   = 1'b0;
                n_best_d2 = D2_W'(r_r2);
                if (r_item.mode) begin
                    n_state = ST_PRUNE;
                end else if (r_item.obj_class != 8'd0) begin
                    n_state = ST_IDLE;
                end else if (r_started_empty) begin
                    n_state = ST_UPD;
                end else begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // Nearest valid track under the radius; ties to the lower id.
                if (d_v && r_valid[d_idx]) begin
                    if (d_d2 < r_best_d2 ||
                        (r_found && d_d2 == r_best_d2 && d_id < r_best.id)) begin
                        n_found    = 1'b1;
                        n_best_d2  = d_d2;
                        n_best_idx = d_idx;
                        n_best.id  = d_id;
                    end
                end
                if (r_cnt == CNT_SCAN) begin
                    n_state = ST_UPD;
                end
            end
            ST_UPD: begin
                mem_wd.cx  = r_dcx;
                mem_wd.cy  = r_dcy;
                mem_wd.bx  = r_item.box_x;
                mem_wd.by  = r_item.box_y;
                mem_wd.bw  = r_item.box_w;
                mem_wd.bh  = r_item.box_h;
                mem_wd.age = 8'd0;
                if (r_found) begin
                    mem_we    = 1'b1;
                    mem_wa    = r_best_idx;
                    mem_wd.id = r_best.id;
                end else if (has_free) begin
                    mem_we            = 1'b1;
                    mem_wa            = free_idx;
                    mem_wd.id         = r_next_id;
                    n_valid[free_idx] = 1'b1;
                    n_next_id         = r_next_id + 32'd1;
                end else begin
                    n_ovf = 1'b1;
                end
                n_state = ST_IDLE;
            end
            ST_PRUNE: begin
                // Drop stale tracks and mark those to report.
                if (r_rd_v) begin
                    if (r_valid[r_rd_idx]) begin
                        if (!r_started_empty && mem_rd.age > r_limit) begin
                            n_valid[r_rd_idx] = 1'b0;
                            n_elig[r_rd_idx]  = 1'b0;
                        end else begin
                            n_elig[r_rd_idx] = (mem_rd.age < 8'd2);
                        end
                    end else begin
                        n_elig[r_rd_idx] = 1'b0;
                    end
                end
                if (r_cnt == CNT_N) begin
                    n_state      = ST_SORT;
                    n_emit       = 1'b0;
                    n_cnt        = '0;
                    n_found      = 1'b0;
                    n_frame_open = 1'b0;
                end
            end
            ST_SORT: begin
                if (!r_emit) begin
                    // Selection pass for the smallest id, ties to the lower slot.
                    if (r_rd_v && r_elig[r_rd_idx] && (!r_found || mem_rd.id < r_best.id)) begin
                        n_found    = 1'b1;
                        n_best     = mem_rd;
                        n_best_idx = r_rd_idx;
                    end
                    if (r_cnt == CNT_N) begin
                        n_emit = 1'b1;
                    end
                end else if (out_free) begin
                    // Load the output register with the selected track or the marker.
                    n_out_valid = 1'b1;
                    n_out       = '0;
                    n_out.overflow = r_ovf;
                    if (r_found) begin
                        n_out.valid_res    = 1'b1;
                        n_out.track_id     = r_best.id;
                        n_out.center_x     = r_best.cx;
                        n_out.center_y     = r_best.cy;
                        n_out.out_x        = r_best.bx;
                        n_out.out_y        = r_best.by;
                        n_out.out_w        = r_best.bw;
                        n_out.out_h        = r_best.bh;
                        n_out.age          = r_best.age[0];
                        n_out.last         = emit_last;
                        n_elig[r_best_idx] = 1'b0;
                        n_emit             = 1'b0;
                        n_cnt              = '0;
                        n_found            = 1'b0;
                        n_state            = emit_last ? ST_IDLE : ST_SORT;
                    end else begin
                        n_out.last = 1'b1;
                        n_state    = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_emit          <= 1'b0;
            r_cnt           <= '0;
            r_valid         <= '0;
            r_elig          <= '0;
            r_frame_open    <= 1'b0;
            r_started_empty <= 1'b0;
            r_ovf           <= 1'b0;
            r_next_id       <= '0;
            r_found         <= 1'b0;
            r_rd_v          <= 1'b0;
            r_out_valid     <= 1'b0;
            r_limit         <= 8'd30;
            r_radius        <= 13'd50;
        end else begin
            r_state         <= n_state;
            r_emit          <= n_emit;
            r_cnt           <= n_cnt;
            r_valid         <= n_valid;
            r_elig          <= n_elig;
            r_frame_open    <= n_frame_open;
            r_started_empty <= n_started_empty;
            r_ovf           <= n_ovf;
            r_next_id       <= n_next_id;
            r_found         <= n_found;
            r_rd_v          <= issue;
            r_out_valid     <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MISSING_LIMIT: r_limit  <= i_cfg_data[7:0];
                    CFG_MATCH_RADIUS:  r_radius <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
        r_item     <= n_item;
        r_dcx      <= n_dcx;
        r_dcy      <= n_dcy;
        r_r2       <= n_r2;
        r_best     <= n_best;
        r_best_idx <= n_best_idx;
        r_best_d2  <= n_best_d2;
        r_rd_idx   <= r_cnt[AW-1:0];
        r_out      <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The memory is only written by the age sweep and by the update step.
    `GCT_ASSERT_SAME(a_no_write_in_scan, i_clk, i_rst_n,
        r_state == ST_SCAN || r_state == ST_PRUNE || r_state == ST_SORT, !mem_we)
    // A new registration advances the id counter by one.
    `GCT_ASSERT_NEXT(a_id_advance, i_clk, i_rst_n,
        r_state == ST_UPD && !r_found && has_free, r_next_id == $past(r_next_id) + 32'd1)
    // The empty-frame marker is only sent when nothing is left to report.
    `GCT_ASSERT_SAME(a_marker_empty, i_clk, i_rst_n,
        r_state == ST_SORT && r_emit && !r_found, r_elig == '0)
    // A transfer marked last closes the frame.
    `GCT_ASSERT_NEXT(a_last_closes, i_clk, i_rst_n,
        r_state == ST_SORT && r_emit && out_free && (!r_found || emit_last),
        r_state == ST_IDLE && !r_frame_open)

endmodule
